[hw/rtl/assert_macros.svh]
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cle_pkg.sv]
package cle_pkg;

   localparam int CP_WIDTH = 21;

   typedef logic [CP_WIDTH-1:0] cp_type;

   // control codes
   localparam cp_type CP_BS     = 21'd8;
   localparam cp_type CP_TAB    = 21'd9;
   localparam cp_type CP_LF     = 21'd10;
   localparam cp_type CP_CR     = 21'd13;
   localparam cp_type CP_SP     = 21'd32;
   localparam cp_type CP_CTRL_U = 21'd21;
   localparam cp_type CP_CTRL_W = 21'd23;

   // shift command for the row of cells
   typedef struct packed {
      logic push;   // every cell takes its lower neighbor, cell 0 takes insert data
      logic pop;    // every cell takes its upper neighbor, the last cell keeps its own value
   } cell_cmd_type;

   function automatic logic is_blank(cp_type c);
      return (c == CP_SP) || (c == CP_TAB);
   endfunction

   function automatic logic is_word_break(cp_type c);
      return (c == CP_SP) || (c == CP_TAB) || (c == CP_LF) || (c == CP_CR);
   endfunction

   // unicode white space as used for trimming
   function automatic logic is_trim_space(cp_type c);
      return ((c >= 21'd9) && (c <= 21'd13)) ||
             (c == 21'h20) || (c == 21'h85) || (c == 21'hA0) || (c == 21'h1680) ||
             ((c >= 21'h2000) && (c <= 21'h200A)) ||
             (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
             (c == 21'h205F) || (c == 21'h3000);
   endfunction

endpackage

[hw/rtl/cle_cell.sv]
module cle_cell (
   input  logic                 clock,
   input  cle_pkg::cell_cmd_type cmd,
   input  cle_pkg::cp_type      lower_data,
   input  cle_pkg::cp_type      upper_data,
   output cle_pkg::cp_type      data
);
   import cle_pkg::*;

   cp_type data_ff;
   cp_type data_in;

   // shift toward either neighbor or hold
   always_comb begin
      data_in = data_ff;
      if (cmd.push) begin
         data_in = lower_data;
      end else if (cmd.pop) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[hw/rtl/cle_ctrl.sv]
module cle_ctrl #(
   parameter int LINE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cle_pkg::cp_type                    req_codepoint,
   input  logic                               req_end_of_line,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cle_pkg::cp_type                    rsp_out_codepoint,
   output logic                               rsp_last,
   output logic                               rsp_empty_line,
   output logic                               rsp_overflowed,
   output cle_pkg::cell_cmd_type              cell_cmd,
   output cle_pkg::cp_type                    ins_data,
   input  cle_pkg::cp_type                    near_data,
   input  cle_pkg::cp_type                    far_data,
   output logic [$clog2(LINE_DEPTH+1)-1:0]    fill_count
);
   import cle_pkg::*;

   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int HW = $clog2(LINE_DEPTH);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_KILL_LINE  = 4'd1;
   localparam logic [3:0] ST_WORD_BLANK = 4'd2;
   localparam logic [3:0] ST_WORD_BODY  = 4'd3;
   localparam logic [3:0] ST_TRIM_TAIL  = 4'd4;
   localparam logic [3:0] ST_ALIGN      = 4'd5;
   localparam logic [3:0] ST_TRIM_HEAD  = 4'd6;
   localparam logic [3:0] ST_EMIT       = 4'd7;
   localparam logic [3:0] ST_EMIT_EMPTY = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [HW-1:0] head_ff, head_in;
   logic          ovf_ff, ovf_in;

   logic          rsp_valid_ff, rsp_valid_in;
   cp_type        rsp_cp_ff, rsp_cp_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_empty_ff, rsp_empty_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          out_free;
   logic          load;
   logic          cnt_nz;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_nz   = (cnt_ff != '0);

   // sequencer: edits, word and line erase walks, trim and emit
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      ovf_in       = ovf_ff;
      cell_cmd     = '0;
      ins_data     = req_codepoint;
      load         = 1'b0;
      rsp_cp_in    = far_data;
      rsp_last_in  = (cnt_ff == CW'(1));
      rsp_empty_in = 1'b0;
      rsp_ovf_in   = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_end_of_line) begin
                  state_in = ST_TRIM_TAIL;
               end else begin
                  unique case (req_codepoint)
                     CP_BS: begin
                        if (cnt_nz) begin
                           cell_cmd.pop = 1'b1;
                           cnt_in       = cnt_ff - CW'(1);
                        end
                     end
                     CP_CTRL_U: state_in = ST_KILL_LINE;
                     CP_CTRL_W: state_in = ST_WORD_BLANK;
                     default: begin
                        if (cnt_ff != CW'(LINE_DEPTH)) begin
                           cell_cmd.push = 1'b1;
                           cnt_in        = cnt_ff + CW'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_KILL_LINE: begin
            if (cnt_nz && (near_data != CP_LF)) begin
               cell_cmd.pop = 1'b1;
               cnt_in       = cnt_ff - CW'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WORD_BLANK: begin
            if (cnt_nz && is_blank(near_data)) begin
               cell_cmd.pop = 1'b1;
               cnt_in       = cnt_ff - CW'(1);
            end else begin
               state_in = ST_WORD_BODY;
            end
         end
         ST_WORD_BODY: begin
            if (cnt_nz && !is_word_break(near_data)) begin
               cell_cmd.pop = 1'b1;
               cnt_in       = cnt_ff - CW'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TRIM_TAIL: begin
            if (cnt_nz && is_trim_space(near_data)) begin
               cell_cmd.pop = 1'b1;
               cnt_in       = cnt_ff - CW'(1);
            end else if (!cnt_nz) begin
               state_in = ST_EMIT_EMPTY;
            end else begin
               head_in  = HW'(cnt_ff - CW'(1));
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // move the oldest entry up to the far end of the row
            if (head_ff != HW'(LINE_DEPTH - 1)) begin
               cell_cmd.push = 1'b1;
               head_in       = head_ff + HW'(1);
            end else begin
               state_in = ST_TRIM_HEAD;
            end
         end
         ST_TRIM_HEAD: begin
            if (cnt_nz && is_trim_space(far_data)) begin
               cell_cmd.push = 1'b1;
               cnt_in        = cnt_ff - CW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load          = 1'b1;
               cell_cmd.push = 1'b1;
               cnt_in        = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_EMPTY: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_cp_in    = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      if (load) begin
         rsp_cp_ff    <= rsp_cp_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_codepoint = rsp_cp_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_empty_line    = rsp_empty_ff;
   assign rsp_overflowed    = rsp_ovf_ff;
   assign fill_count        = cnt_ff;

endmodule

[hw/rtl/command_line_editor_top.sv]
// Line editor for a typed command line. Each request carries one codepoint;
// backspace, Ctrl-U and Ctrl-W edit the line, anything else is appended, and an
// end-of-line request emits the line with Unicode white space trimmed at both
// ends (one flagged item when nothing is left), then starts a new line. The
// line lives in a row of LINE_DEPTH cells used as a stack, newest entry at
// cell 0. Append and backspace are done in the idle state; Ctrl-U and Ctrl-W
// erase entries one at a time. End of line removes trailing blanks, shifts
// the oldest entry to the far end of the row, removes leading blanks, then
// emits the codepoints oldest first while the result side does not stall.
// The cell row shifts one entry at a time. A result waits in an output
// register, so the next request can be taken while the last result of a
// line is still pending.
module command_line_editor_top #(
   parameter int LINE_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  cle_pkg::cp_type req_codepoint,
   input  logic            req_end_of_line,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output cle_pkg::cp_type rsp_out_codepoint,
   output logic            rsp_last,
   output logic            rsp_empty_line,
   output logic            rsp_overflowed
);
   import cle_pkg::*;

`include "assert_macros.svh"

   localparam int CW = $clog2(LINE_DEPTH + 1);

   cell_cmd_type  cell_cmd;
   cp_type        ins_data;
   cp_type        cell_data [LINE_DEPTH];
   logic [CW-1:0] fill_count;
   logic [CW-1:0] fill_up;
   logic          empty_item;
   logic          cp_zero;
   logic          bs_take;

   // sequencer and output register
   cle_ctrl #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_codepoint     (req_codepoint),
      .req_end_of_line   (req_end_of_line),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_codepoint (rsp_out_codepoint),
      .rsp_last          (rsp_last),
      .rsp_empty_line    (rsp_empty_line),
      .rsp_overflowed    (rsp_overflowed),
      .cell_cmd          (cell_cmd),
      .ins_data          (ins_data),
      .near_data         (cell_data[0]),
      .far_data          (cell_data[LINE_DEPTH-1]),
      .fill_count        (fill_count)
   );

   // row of line cells
   for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
      cp_type lower;
      cp_type upper;
      if (i == 0) begin : g_first
         assign lower = ins_data;
      end else begin : g_mid_lo
         assign lower = cell_data[i-1];
      end
      if (i == LINE_DEPTH - 1) begin : g_last
         assign upper = cell_data[i];
      end else begin : g_mid_hi
         assign upper = cell_data[i+1];
      end
      cle_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[i])
      );
   end

   // terms for the checks
   assign fill_up    = fill_count + CW'(1);
   assign empty_item = rsp_valid && rsp_empty_line;
   assign cp_zero    = (rsp_out_codepoint == '0);
   assign bs_take    = req_valid && !req_stall && !req_end_of_line &&
                       (req_codepoint == CP_BS) && (fill_count != '0);

   // checks
   `ASSERT_IMPL(a_empty_is_last, clock, reset, empty_item, rsp_last, "empty item not last")
   `ASSERT_IMPL(a_empty_zero_cp, clock, reset, empty_item, cp_zero, "empty item with data")
   `ASSERT_NEXT(a_bs_drop, clock, reset, bs_take, fill_up == $past(fill_count), "no drop")
   `ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_count <= CW'(LINE_DEPTH), "fill overrun")

endmodule

[verif/command_line_editor_top_tb.sv]
`timescale 1ns / 1ps

module command_line_editor_top_tb;
   import cle_pkg::*;

   localparam int LINE_DEPTH = 64;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned RANDOM_ITEMS = 480;
   localparam int unsigned TAIL_CYCLES = 3 * LINE_DEPTH + 20;

   // unicode white space other than tab, lf, cr and space
   localparam cp_type WIDE_SPACES [13] = '{
      21'd11, 21'd12, 21'h85, 21'hA0, 21'h1680, 21'h2000, 21'h2005, 21'h200A,
      21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000};

   // values right next to the white space ranges, and the largest codepoint
   localparam cp_type NEAR_SPACES [13] = '{
      21'd14, 21'h1F, 21'h21, 21'h84, 21'h86, 21'h9F, 21'hA1, 21'h167F,
      21'h1FFF, 21'h200B, 21'h2027, 21'h3001, 21'h1FFFFF};

   typedef struct packed {
      cp_type cp;
      logic   last;
      logic   empty_line;
      logic   overflowed;
   } emitted_char_type;

   // line buffer shadow and queue of trimmed characters still to come
   class line_tracker_type;
      cp_type           held [LINE_DEPTH];
      int unsigned      fill;
      bit               dropped;
      emitted_char_type waiting [$];
      int unsigned      mismatches;
      int unsigned      chars_checked;

      function new();
         fill = 0;
         dropped = 0;
         mismatches = 0;
         chars_checked = 0;
      endfunction

      function bit trims_away(cp_type c);
         return (c >= 21'd9 && c <= 21'd13) || c == 21'h20 || c == 21'h85 ||
                c == 21'hA0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) ||
                c == 21'h2028 || c == 21'h2029 || c == 21'h202F ||
                c == 21'h205F || c == 21'h3000;
      endfunction

      function bit is_gap(cp_type c);
         return c == CP_SP || c == CP_TAB;
      endfunction

      function bit breaks_word(cp_type c);
         return c == CP_SP || c == CP_TAB || c == CP_LF || c == CP_CR;
      endfunction

      function int unsigned pending();
         return waiting.size();
      endfunction

      // apply one accepted request, queue the characters it emits
      function void apply_keystroke(cp_type cp, logic eol);
         int unsigned      lo;
         int unsigned      hi;
         int unsigned      p;
         emitted_char_type ch;
         if (eol) begin
            lo = 0;
            hi = fill;
            while (lo < hi && trims_away(held[lo])) lo++;
            while (hi > lo && trims_away(held[hi - 1])) hi--;
            if (lo == hi) begin
               ch = '{cp: '0, last: 1'b1, empty_line: 1'b1, overflowed: dropped};
               waiting.push_back(ch);
            end else begin
               for (int unsigned k = lo; k < hi; k++) begin
                  ch = '{cp: held[k], last: (k + 1 == hi), empty_line: 1'b0,
                         overflowed: dropped};
                  waiting.push_back(ch);
               end
            end
            fill = 0;
            dropped = 0;
         end else begin
            case (cp)
               CP_BS: begin
                  if (fill > 0) fill--;
               end
               CP_CTRL_U: begin
                  p = fill;
                  while (p > 0 && held[p - 1] != CP_LF) p--;
                  fill = p;
               end
               CP_CTRL_W: begin
                  p = fill;
                  while (p > 0 && is_gap(held[p - 1])) p--;
                  while (p > 0 && !breaks_word(held[p - 1])) p--;
                  fill = p;
               end
               default: begin
                  if (fill < LINE_DEPTH) begin
                     held[fill] = cp;
                     fill++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
            endcase
         end
      endfunction

      // compare one accepted result with the oldest queued character
      function void check_emitted(emitted_char_type got);
         emitted_char_type want;
         chars_checked++;
         if (waiting.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: cp=%h last=%b empty=%b ovf=%b",
                        got.cp, got.last, got.empty_line, got.overflowed);
            mismatches++;
            return;
         end
         want = waiting.pop_front();
         if (got.cp !== want.cp || got.last !== want.last ||
             got.empty_line !== want.empty_line || got.overflowed !== want.overflowed) begin
            if (mismatches < 10)
               $display({"result %0d mismatch: expected cp=%h last=%b empty=%b ovf=%b,",
                         " got cp=%h last=%b empty=%b ovf=%b"}, chars_checked,
                        want.cp, want.last, want.empty_line, want.overflowed,
                        got.cp, got.last, got.empty_line, got.overflowed);
            mismatches++;
         end
      endfunction
   endclass

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_stall;
   cp_type req_codepoint = '0;
   logic   req_end_of_line = 1'b0;
   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   cp_type rsp_out_codepoint;
   logic   rsp_last;
   logic   rsp_empty_line;
   logic   rsp_overflowed;

   line_tracker_type tracker = new();
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;

   command_line_editor_top #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_codepoint(req_codepoint),
      .req_end_of_line(req_end_of_line),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_codepoint(rsp_out_codepoint),
      .rsp_last(rsp_last),
      .rsp_empty_line(rsp_empty_line),
      .rsp_overflowed(rsp_overflowed)
   );

   // clock
   always #5 clock = ~clock;

   // offer one request, with a random gap at the start of each burst
   task automatic offer(cp_type cp, logic eol);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_codepoint <= cp;
      req_end_of_line <= eol;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.apply_keystroke(cp, eol);
      items_sent++;
      burst_left--;
   endtask

   // mostly text, white space and edit commands, some of the full range
   function automatic cp_type pick_keystroke(bit mostly_text);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (mostly_text && r < 70) return cp_type'($urandom_range(33, 126));
      if (r < 35) return cp_type'($urandom_range(33, 126));
      else if (r < 47) return CP_SP;
      else if (r < 52) return CP_TAB;
      else if (r < 56) return CP_LF;
      else if (r < 59) return CP_CR;
      else if (r < 67) return WIDE_SPACES[$urandom_range(0, 12)];
      else if (r < 75) return CP_BS;
      else if (r < 78) return CP_CTRL_U;
      else if (r < 83) return CP_CTRL_W;
      else if (r < 92) return cp_type'($urandom_range(0, 21'h1FFFFF));
      return NEAR_SPACES[$urandom_range(0, 12)];
   endfunction

   // one line of random keystrokes closed by end of line, now and then past full
   task automatic send_random_line();
      bit          long_line;
      int unsigned len;
      long_line = ($urandom_range(0, 11) == 0);
      len = long_line ? $urandom_range(64, 80) : $urandom_range(0, 24);
      repeat (len) offer(pick_keystroke(long_line), 1'b0);
      offer(cp_type'($urandom_range(0, 21'h1FFFFF)), 1'b1);
   endtask

   // stop sending until every queued character has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // result side: random stall stretches plus one long hold-off
   initial begin : result_sink
      int unsigned stretch_left;
      int unsigned stall_pct;
      int unsigned hold_left;
      bit          hold_done;
      stretch_left = 0;
      stall_pct = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            tracker.check_emitted(emitted_char_type'{cp: rsp_out_codepoint, last: rsp_last,
                                                     empty_line: rsp_empty_line,
                                                     overflowed: rsp_overflowed});
         if (!hold_done && tracker.chars_checked >= 40) begin
            hold_done = 1'b1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(1, 60);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 30;
                  3: stall_pct = 70;
                  default: stall_pct = 90;
               endcase
            end
            stretch_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // watchdog on cycles with no request or result accepted
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("command_line_editor_top_tb failed");
      $finish;
   end

   // reset, directed lines, random lines, drain and verdict
   initial begin : stimulus
      bit drained;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // end of line on an empty buffer
      offer(cp_type'($urandom_range(0, 21'h1FFFFF)), 1'b1);
      // backspace on empty buffer, trimming, field extremes
      offer(CP_BS, 1'b0);
      offer(21'h61, 1'b0);
      offer(CP_SP, 1'b0);
      offer(21'h3000, 1'b0);
      offer(21'h1FFFFF, 1'b0);
      offer(21'h0, 1'b0);
      offer(CP_TAB, 1'b0);
      offer(21'h1FFFFF, 1'b1);
      // ctrl-u back to lf, surrogate stored, ctrl-w stops at lf
      offer(21'h78, 1'b0);
      offer(CP_LF, 1'b0);
      offer(21'h79, 1'b0);
      offer(CP_CTRL_U, 1'b0);
      offer(21'hD800, 1'b0);
      offer(CP_CTRL_W, 1'b0);
      offer(21'h0, 1'b1);
      // ctrl-w skips trailing blanks and keeps the space, ctrl-u without lf clears
      offer(21'h70, 1'b0);
      offer(CP_SP, 1'b0);
      offer(21'h71, 1'b0);
      offer(CP_TAB, 1'b0);
      offer(CP_CTRL_W, 1'b0);
      offer(CP_CTRL_U, 1'b0);
      offer(21'h155555, 1'b1);
      // line of white space only
      offer(CP_SP, 1'b0);
      offer(21'h85, 1'b0);
      offer(21'h0AAAAA, 1'b1);

      // random lines, with one full drain partway
      while (items_sent < RANDOM_ITEMS + 26) begin
         send_random_line();
         if (!drained && items_sent >= 260) begin
            drained = 1'b1;
            wait_for_drain();
         end
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("command_line_editor_top_tb passed");
      else
         $display("command_line_editor_top_tb failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/cle_pkg.sv
hw/rtl/cle_cell.sv
hw/rtl/cle_ctrl.sv
hw/rtl/command_line_editor_top.sv
verif/command_line_editor_top_tb.sv
